/* rtl/core/hbp_pkg.sv */
// Shared types and constants for the variable-length code bit packer.
// Used by hbp_ctrl, hbp_datapath and huffman_bit_packer_unit; depends on nothing.
`default_nettype none

package hbp_pkg;

   localparam int MAX_CODE_LEN = 32;
   localparam int SYMBOL_COUNT = 256;

   localparam int CMD_W       = 2;
   localparam int SYMBOL_W    = 8;
   localparam int CODE_W      = 32;
   localparam int CODE_LEN_W  = 6;
   localparam int BYTE_W      = 8;
   localparam int FILL_W      = 3;
   localparam int REQ_FIELD_W = SYMBOL_W + CODE_W + CODE_LEN_W;
   localparam int REQ_TDATA_W = ((REQ_FIELD_W + 7) / 8) * 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD   = 2'd0,
      CMD_ENCODE = 2'd1,
      CMD_FLUSH  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic mem_wr;
      logic build;
      logic flush_start;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic sym_ok;
      logic fill_nz;
      logic count_zero;
      logic rsp_valid;
   } dp_status_type;

endpackage

`default_nettype wire

/* rtl/core/hbp_ctrl.sv */
// Controller state machine of the bit packer: accepts requests and sequences the datapath.
// Depends on hbp_pkg for the state, command and status types.
`default_nettype none

module hbp_ctrl (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_tvalid,
   output logic                      req_tready,
   input  wire  [hbp_pkg::CMD_W-1:0] req_cmd,
   input  wire                       rsp_tready,
   input  wire  hbp_pkg::dp_status_type status,
   output hbp_pkg::ctrl_cmd_type     cmd
);

   hbp_pkg::state_type state_ff;
   hbp_pkg::state_type state_in;
   hbp_pkg::cmd_type   req_kind;

   assign req_kind = hbp_pkg::cmd_type'(req_cmd);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hbp_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      req_tready      = 1'b0;
      cmd.mem_wr      = 1'b0;
      cmd.build       = 1'b0;
      cmd.flush_start = 1'b0;
      cmd.emit        = 1'b0;
      unique case (state_ff)
         hbp_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               unique case (req_kind)
                  hbp_pkg::CMD_LOAD: begin
                     cmd.mem_wr = status.sym_ok;
                  end
                  hbp_pkg::CMD_ENCODE: begin
                     if (status.sym_ok) begin
                        state_in = hbp_pkg::S_LOOKUP;
                     end
                  end
                  hbp_pkg::CMD_FLUSH: begin
                     if (status.fill_nz) begin
                        cmd.flush_start = 1'b1;
                        state_in        = hbp_pkg::S_EMIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         hbp_pkg::S_LOOKUP: begin
            cmd.build = 1'b1;
            state_in  = hbp_pkg::S_EMIT;
         end
         hbp_pkg::S_EMIT: begin
            if (status.count_zero) begin
               state_in = hbp_pkg::S_IDLE;
            end else begin
               cmd.emit = !status.rsp_valid || rsp_tready;
            end
         end
         default: begin
            state_in = hbp_pkg::S_IDLE;
         end
      endcase
   end

   // A code is only merged on the cycle after an encode request was taken.
   a_build_after_encode: assert property (@(posedge clock) disable iff (reset)
      cmd.build |-> $past(req_tvalid && req_tready && req_kind == hbp_pkg::CMD_ENCODE))
      else $error("code merge without a preceding encode request");

   // No request is taken while bytes are still being produced.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != hbp_pkg::S_IDLE) |-> !req_tready)
      else $error("request taken while busy");

   a_emit_in_emit_state: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (state_ff == hbp_pkg::S_EMIT))
      else $error("byte emitted outside the emit state");

endmodule

`default_nettype wire

/* rtl/core/hbp_datapath.sv */
// Datapath of the bit packer: code memory, bit buffer, byte counter and output register.
// Depends on hbp_pkg; driven by commands from hbp_ctrl.
`default_nettype none

module hbp_datapath #(
   parameter int MAX_CODE_LEN = hbp_pkg::MAX_CODE_LEN,
   parameter int SYMBOL_COUNT = hbp_pkg::SYMBOL_COUNT
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_accept,
   input  wire  [hbp_pkg::SYMBOL_W-1:0]   symbol,
   input  wire  [hbp_pkg::CODE_W-1:0]     code_bits,
   input  wire  [hbp_pkg::CODE_LEN_W-1:0] code_len,
   input  wire                            rsp_tready,
   input  wire  hbp_pkg::ctrl_cmd_type    cmd,
   output hbp_pkg::dp_status_type         status,
   output logic                           rsp_tvalid,
   output logic [hbp_pkg::BYTE_W-1:0]     rsp_byte,
   output logic                           rsp_last
);

   localparam int ADDR_W  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   localparam int LEN_W   = $clog2(MAX_CODE_LEN + 1);
   localparam int ENTRY_W = LEN_W + MAX_CODE_LEN;
   localparam int BUF_W   = MAX_CODE_LEN + hbp_pkg::BYTE_W;
   localparam int TOT_W   = $clog2(BUF_W);
   localparam int CNT_W   = TOT_W - hbp_pkg::FILL_W;
   localparam int SH_W    = $clog2(BUF_W + 1);

   logic [ENTRY_W-1:0]            mem [SYMBOL_COUNT];
   logic [ENTRY_W-1:0]            rd_ff;
   logic [BUF_W-1:0]              buf_ff;
   logic [BUF_W-1:0]              buf_in;
   logic [CNT_W-1:0]              count_ff;
   logic [CNT_W-1:0]              count_in;
   logic [hbp_pkg::FILL_W-1:0]    fill_ff;
   logic [hbp_pkg::FILL_W-1:0]    fill_in;
   logic                          rsp_valid_ff;
   logic [hbp_pkg::BYTE_W-1:0]    rsp_byte_ff;
   logic                          rsp_last_ff;
   logic [ADDR_W-1:0]             addr;
   logic [LEN_W-1:0]              wr_len;
   logic [LEN_W-1:0]              rd_len;
   logic [MAX_CODE_LEN-1:0]       rd_code;
   logic [MAX_CODE_LEN-1:0]       len_mask;
   logic [TOT_W-1:0]              total;
   logic [SH_W-1:0]               shamt;
   logic [BUF_W-1:0]              placed;

   assign addr   = symbol[ADDR_W-1:0];
   assign wr_len = (code_len > hbp_pkg::CODE_LEN_W'(MAX_CODE_LEN)) ?
                   LEN_W'(MAX_CODE_LEN) : code_len[LEN_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         mem[addr] <= {wr_len, code_bits[MAX_CODE_LEN-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_ff <= mem[addr];
      end
   end

   assign rd_len   = rd_ff[ENTRY_W-1 -: LEN_W];
   assign rd_code  = rd_ff[MAX_CODE_LEN-1:0];
   assign len_mask = ~({MAX_CODE_LEN{1'b1}} << rd_len);
   assign total    = TOT_W'(fill_ff) + TOT_W'(rd_len);
   assign shamt    = SH_W'(BUF_W) - SH_W'(total);
   assign placed   = BUF_W'(rd_code & len_mask) << shamt;

   // The top byte of the buffer is the partial output byte; lower bits stay zero when idle.
   always_comb begin
      buf_in   = buf_ff;
      count_in = count_ff;
      fill_in  = fill_ff;
      if (cmd.build) begin
         buf_in   = buf_ff | placed;
         count_in = total[TOT_W-1:hbp_pkg::FILL_W];
         fill_in  = total[hbp_pkg::FILL_W-1:0];
      end else if (cmd.flush_start) begin
         count_in = CNT_W'(1);
         fill_in  = '0;
      end else if (cmd.emit) begin
         buf_in   = buf_ff << hbp_pkg::BYTE_W;
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff   <= '0;
         count_ff <= '0;
         fill_ff  <= '0;
      end else begin
         buf_ff   <= buf_in;
         count_ff <= count_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_byte_ff <= buf_ff[BUF_W-1 -: hbp_pkg::BYTE_W];
         rsp_last_ff <= (count_ff == CNT_W'(1));
      end
   end

   assign status.sym_ok     = ({1'b0, symbol} < (hbp_pkg::SYMBOL_W + 1)'(SYMBOL_COUNT));
   assign status.fill_nz    = (fill_ff != '0);
   assign status.count_zero = (count_ff == '0);
   assign status.rsp_valid  = rsp_valid_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_byte   = rsp_byte_ff;
   assign rsp_last   = rsp_last_ff;

   a_emit_needs_count: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (count_ff != '0))
      else $error("byte emitted with no byte pending");

   a_last_on_final: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && count_ff == CNT_W'(1)) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("final byte of a request not marked last");

   a_flush_clears_fill: assert property (@(posedge clock) disable iff (reset)
      cmd.flush_start |=> (fill_ff == '0 && count_ff == CNT_W'(1)))
      else $error("flush did not leave one byte pending and empty fill");

endmodule

`default_nettype wire

/* rtl/core/huffman_bit_packer_unit.sv */
// Top level of the variable-length code bit packer: request and result streams.
// Instantiates hbp_ctrl and hbp_datapath; depends on hbp_pkg.
//
//   Channel  Direction  Payload
//   req_     in         tuser = cmd; tdata = symbol, code_bits, code_len
//   rsp_     out        tdata = packed_byte; tlast = last
//
// A load, an unused command or an empty flush is finished in the idle state that accepts it.
// An encode reads the code memory on accept, merges the code in the lookup state, then emits
// its bytes in the emit state and returns to idle; a flush with pending bits goes straight to emit.
// A new request is taken only when the unit is idle; the last byte may still wait in the
// output register. A stall on rsp_tready holds byte emission.
// Reset clears the bit buffer and control state; code entries are undefined until loaded.
`default_nettype none

module huffman_bit_packer_unit #(
   parameter int MAX_CODE_LEN = hbp_pkg::MAX_CODE_LEN,
   parameter int SYMBOL_COUNT = hbp_pkg::SYMBOL_COUNT
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // [7:0] symbol, [39:8] code_bits, [45:40] code_len, [47:46] zero
   input  wire  [hbp_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [1:0] cmd
   input  wire  [hbp_pkg::CMD_W-1:0]        req_tuser,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // [7:0] packed_byte
   output logic [hbp_pkg::BYTE_W-1:0]       rsp_tdata,
   output logic                             rsp_tlast
);

   localparam int SYM_LO = 0;
   localparam int CODE_LO = SYM_LO + hbp_pkg::SYMBOL_W;
   localparam int LEN_LO = CODE_LO + hbp_pkg::CODE_W;

   hbp_pkg::ctrl_cmd_type  cmd;
   hbp_pkg::dp_status_type status;
   logic                   req_accept;

   assign req_accept = req_tvalid && req_tready;

   hbp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   hbp_datapath #(
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .SYMBOL_COUNT (SYMBOL_COUNT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .symbol     (req_tdata[SYM_LO +: hbp_pkg::SYMBOL_W]),
      .code_bits  (req_tdata[CODE_LO +: hbp_pkg::CODE_W]),
      .code_len   (req_tdata[LEN_LO +: hbp_pkg::CODE_LEN_W]),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_byte   (rsp_tdata),
      .rsp_last   (rsp_tlast)
   );

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for huffman_bit_packer_unit: it loads code entries, encodes symbols and
// flushes, predicts every packed byte, and checks each byte as it arrives on the result stream.
// Depends on hbp_pkg and the huffman_bit_packer_unit RTL.

module tb_top;
   import hbp_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_REQUESTS = 310;

   typedef struct packed {
      logic [BYTE_W-1:0] value;
      logic              last;
   } packed_byte_type;

   typedef enum {
      READY_ALWAYS,
      READY_HALF,
      READY_SPARSE,
      READY_PERIODIC
   } ready_mode_type;

   class packed_byte_scoreboard;
      logic [CODE_W-1:0]     code_word [SYMBOL_COUNT];
      int                    code_length [SYMBOL_COUNT];
      logic [BYTE_W-1:0]     acc_byte;
      int                    acc_count;
      packed_byte_type       expected_bytes [$];
      int                    failures;

      function new();
         acc_byte = '0;
         acc_count = 0;
         failures = 0;
         foreach (code_length[i]) begin
            code_word[i] = '0;
            code_length[i] = 0;
         end
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction

      // Packs the stored code of a symbol, first code bit into bit 7 of the open byte.
      function void pack_symbol(int sym);
         logic [CODE_W-1:0] word;
         logic [BYTE_W-1:0] done_bytes [4];
         int                count;
         packed_byte_type   entry;
         word = code_word[sym];
         count = 0;
         for (int i = code_length[sym] - 1; i >= 0; i--) begin
            acc_byte[7 - acc_count] = word[i];
            acc_count++;
            if (acc_count == 8) begin
               done_bytes[count] = acc_byte;
               count++;
               acc_byte = '0;
               acc_count = 0;
            end
         end
         for (int k = 0; k < count; k++) begin
            entry.value = done_bytes[k];
            entry.last = (k == count - 1);
            expected_bytes = {expected_bytes, entry};
         end
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic [SYMBOL_W-1:0] sym,
                                 logic [CODE_W-1:0] code, logic [CODE_LEN_W-1:0] len);
         packed_byte_type entry;
         if (cmd == CMD_LOAD) begin
            code_word[sym] = code;
            code_length[sym] = (len > MAX_CODE_LEN) ? MAX_CODE_LEN : int'(len);
         end else if (cmd == CMD_ENCODE) begin
            pack_symbol(int'(sym));
         end else if (cmd == CMD_FLUSH && acc_count != 0) begin
            entry.value = acc_byte;
            entry.last = 1'b1;
            expected_bytes = {expected_bytes, entry};
            acc_byte = '0;
            acc_count = 0;
         end
      endfunction

      function void check_byte(logic [BYTE_W-1:0] value, logic last);
         packed_byte_type want;
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected byte, expected none, actual 0x%02h last %0b",
                     $time, value, last);
            failures++;
            return;
         end
         want = expected_bytes[0];
         expected_bytes.delete(0);
         if (value !== want.value) begin
            $display("%0t: packed byte mismatch, expected 0x%02h, actual 0x%02h",
                     $time, want.value, value);
            failures++;
         end
         if (last !== want.last) begin
            $display("%0t: last flag mismatch, expected %0b, actual %0b",
                     $time, want.last, last);
            failures++;
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata = '0;
   logic [CMD_W-1:0]        req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [BYTE_W-1:0]       rsp_tdata;
   logic                    rsp_tlast;

   packed_byte_scoreboard   scoreboard = new();
   bit                      loaded [SYMBOL_COUNT];
   int                      loaded_symbols [$];
   ready_mode_type          ready_mode = READY_ALWAYS;
   int unsigned             mode_left = 0;

   huffman_bit_packer_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode <= ready_mode_type'($urandom_range(0, 3));
         mode_left <= $urandom_range(20, 150);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (ready_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_HALF: rsp_tready <= ($urandom_range(0, 1) == 1);
         READY_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= mode_left[2];
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         scoreboard.check_byte(rsp_tdata, rsp_tlast);
      end
   end

   // Holds the request until the unit takes it, then records it for prediction.
   task automatic send_request(logic [CMD_W-1:0] cmd, logic [SYMBOL_W-1:0] sym,
                               logic [CODE_W-1:0] code, logic [CODE_LEN_W-1:0] len);
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {2'b00, len, code, sym};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      scoreboard.note_request(cmd, sym, code, len);
      if (cmd == CMD_LOAD && !loaded[sym]) begin
         loaded[sym] = 1'b1;
         loaded_symbols = {loaded_symbols, int'(sym)};
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (scoreboard.pending() != 0) @(posedge clock);
   endtask

   task automatic send_random_request(output bit counted);
      int unsigned pick;
      int unsigned len_pick;
      logic [CODE_LEN_W-1:0] len;
      pick = $urandom_range(0, 99);
      len_pick = $urandom_range(0, 9);
      if (len_pick < 7) len = CODE_LEN_W'($urandom_range(1, 12));
      else if (len_pick == 7) len = '0;
      else if (len_pick == 8) len = CODE_LEN_W'($urandom_range(13, 32));
      else len = CODE_LEN_W'($urandom_range(33, 63));
      counted = 1'b1;
      if (pick < 14) begin
         send_request(CMD_LOAD, SYMBOL_W'($urandom_range(0, 255)), $urandom, len);
      end else if (pick < 78) begin
         send_request(CMD_ENCODE,
                      SYMBOL_W'(loaded_symbols[$urandom_range(0, loaded_symbols.size() - 1)]),
                      $urandom, CODE_LEN_W'($urandom_range(0, 63)));
      end else if (pick < 94) begin
         send_request(CMD_FLUSH, SYMBOL_W'($urandom_range(0, 255)), $urandom,
                      CODE_LEN_W'($urandom_range(0, 63)));
      end else begin
         send_request(CMD_UNUSED, SYMBOL_W'($urandom_range(0, 255)), $urandom,
                      CODE_LEN_W'($urandom_range(0, 63)));
         counted = 1'b0;
      end
   endtask

   initial begin
      int  sent;
      int  burst;
      bit  counted;
      bit  drained;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests: extreme codes and lengths, empty flush, zero length, unused command.
      send_request(CMD_FLUSH, 8'hff, 32'hffff_ffff, 6'd63);
      send_request(CMD_LOAD, 8'd0, 32'hffff_ffff, 6'd32);
      send_request(CMD_LOAD, 8'd255, 32'h0000_0000, 6'd63);
      send_request(CMD_LOAD, 8'd1, 32'h0000_0005, 6'd3);
      send_request(CMD_LOAD, 8'd2, 32'habcd_ef12, 6'd0);
      send_request(CMD_LOAD, 8'd3, 32'h8000_0001, 6'd1);
      send_request(CMD_LOAD, 8'd128, 32'h1234_5678, 6'd40);
      send_request(CMD_LOAD, 8'd85, 32'haaaa_aaaa, 6'd31);
      send_request(CMD_ENCODE, 8'd0, 32'h0, 6'd0);
      send_request(CMD_ENCODE, 8'd2, 32'hffff_ffff, 6'd63);
      send_request(CMD_ENCODE, 8'd1, 32'h0, 6'd0);
      send_request(CMD_ENCODE, 8'd255, 32'h0, 6'd0);
      send_request(CMD_FLUSH, 8'd0, 32'h0, 6'd0);
      send_request(CMD_UNUSED, 8'hff, 32'hffff_ffff, 6'd63);
      send_request(CMD_ENCODE, 8'd3, 32'h0, 6'd0);
      send_request(CMD_ENCODE, 8'd128, 32'h0, 6'd0);
      send_request(CMD_ENCODE, 8'd85, 32'h0, 6'd0);
      send_request(CMD_ENCODE, 8'd0, 32'h0, 6'd0);
      send_request(CMD_FLUSH, 8'd0, 32'h0, 6'd0);
      send_request(CMD_ENCODE, 8'd3, 32'h0, 6'd0);
      send_request(CMD_FLUSH, 8'd0, 32'h0, 6'd0);
      drain_results();

      sent = 0;
      drained = 1'b0;
      while (sent < RANDOM_REQUESTS) begin
         burst = $urandom_range(1, 24);
         for (int k = 0; k < burst && sent < RANDOM_REQUESTS; k++) begin
            send_random_request(counted);
            if (counted) sent++;
         end
         if (!drained && sent >= RANDOM_REQUESTS / 2) begin
            drained = 1'b1;
            drain_results();
         end else if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end

      drain_results();
      repeat (16) @(posedge clock);
      if (scoreboard.failures == 0 && scoreboard.pending() == 0) begin
         $display("huffman_bit_packer_unit test passed");
      end else begin
         $display("huffman_bit_packer_unit test failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("huffman_bit_packer_unit test failed");
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/hbp_pkg.sv
rtl/core/hbp_ctrl.sv
rtl/core/hbp_datapath.sv
rtl/core/huffman_bit_packer_unit.sv
tb/sv/tb_top.sv
